@@ rtl/yuv_pkg.sv @@
package yuv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIXEL_W = 16;
    localparam int unsigned OFS_W   = 9;
    localparam int unsigned SUM_W   = 11;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] red_ofs;
        logic signed [OFS_W-1:0] green_ofs;
        logic signed [OFS_W-1:0] blue_ofs;
    } chroma_ofs_t;

endpackage

@@ rtl/yuv_chroma.sv @@
module yuv_chroma
(
    input  logic                 clk,
    input  yuv_pkg::byte_t       blue_chroma,
    input  yuv_pkg::byte_t       red_chroma,
    output yuv_pkg::chroma_ofs_t ofs
);
    import yuv_pkg::*;

    localparam logic signed [17:0] COEF_RV = 18'sd359;
    localparam logic signed [17:0] COEF_GU = 18'sd88;
    localparam logic signed [17:0] COEF_GV = 18'sd183;
    localparam logic signed [17:0] COEF_BU = 18'sd454;

    logic signed [OFS_W-1:0] du;
    logic signed [OFS_W-1:0] dv;
    logic signed [17:0]      du_ext;
    logic signed [17:0]      dv_ext;
    logic signed [17:0]      r_prod;
    logic signed [17:0]      g_prod;
    logic signed [17:0]      b_prod;
    chroma_ofs_t             ofs_next;
    chroma_ofs_t             ofs_reg;

    // offset binary to two's complement: x - 128
    assign du     = $signed({~blue_chroma[7], ~blue_chroma[7], blue_chroma[6:0]});
    assign dv     = $signed({~red_chroma[7], ~red_chroma[7], red_chroma[6:0]});
    assign du_ext = {{9{du[OFS_W-1]}}, du};
    assign dv_ext = {{9{dv[OFS_W-1]}}, dv};

    assign r_prod = dv_ext * COEF_RV;
    assign g_prod = du_ext * COEF_GU + dv_ext * COEF_GV;
    assign b_prod = du_ext * COEF_BU;

    // floor divide by 256 is the arithmetic shift; results fit in 9 bits
    always_comb
    begin
        ofs_next.red_ofs   = r_prod[16:8];
        ofs_next.green_ofs = g_prod[16:8];
        ofs_next.blue_ofs  = b_prod[16:8];
    end

    always_ff @(posedge clk)
    begin
        ofs_reg <= ofs_next;
    end

    assign ofs = ofs_reg;

endmodule

@@ rtl/yuv_lane.sv @@
module yuv_lane
(
    input  logic                 clk,
    input  yuv_pkg::byte_t       luma,
    input  yuv_pkg::chroma_ofs_t ofs,
    output yuv_pkg::pixel_t      pixel
);
    import yuv_pkg::*;

    function automatic byte_t clamp_byte(input logic signed [SUM_W-1:0] x);
        byte_t res;
        if (x[SUM_W-1])
        begin
            res = 8'h00;
        end
        else if (x[SUM_W-2:BYTE_W] != '0)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = x[BYTE_W-1:0];
        end
        return res;
    endfunction

    logic signed [SUM_W-1:0] luma_ext;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;
    byte_t                   r_byte;
    byte_t                   g_byte;
    byte_t                   b_byte;
    pixel_t                  pixel_next;
    pixel_t                  pixel_reg;

    assign luma_ext = $signed({3'b000, luma});
    assign r_sum    = luma_ext + {{2{ofs.red_ofs[OFS_W-1]}}, ofs.red_ofs};
    assign g_sum    = luma_ext - {{2{ofs.green_ofs[OFS_W-1]}}, ofs.green_ofs};
    assign b_sum    = luma_ext + {{2{ofs.blue_ofs[OFS_W-1]}}, ofs.blue_ofs};

    assign r_byte     = clamp_byte(r_sum);
    assign g_byte     = clamp_byte(g_sum);
    assign b_byte     = clamp_byte(b_sum);
    assign pixel_next = {r_byte[7:3], g_byte[7:2], b_byte[7:3]};

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

@@ rtl/yuv422_to_rgb565_converter.sv @@
// YUYV 4:2:2 to RGB565 converter. One macropixel transfer is taken in every
// cycle (busy stays low) and its two RGB565 pixels appear on the cycle that
// done is high, after the shared chroma offset register and then the output
// registers of the two per-pixel lanes that clamp and pack. The receiver
// cannot stall, so each result is valid for that single cycle only and must
// be captured then. last_pair_res is delayed through a matching shift register.
module yuv422_to_rgb565_converter
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  yuv_pkg::byte_t  first_luma,
    input  yuv_pkg::byte_t  blue_chroma,
    input  yuv_pkg::byte_t  second_luma,
    input  yuv_pkg::byte_t  red_chroma,
    input  logic            last_pair,
    output logic            done,
    output yuv_pkg::pixel_t first_pixel,
    output yuv_pkg::pixel_t second_pixel,
    output logic            last_pair_res
);
    import yuv_pkg::*;

    logic        accept;
    logic [1:0]  valid_reg;
    logic [1:0]  valid_next;
    logic [1:0]  last_reg;
    byte_t       luma0_reg;
    byte_t       luma1_reg;
    chroma_ofs_t ofs;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign valid_next = {valid_reg[0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        luma0_reg <= first_luma;
        luma1_reg <= second_luma;
        last_reg  <= {last_reg[0], last_pair};
    end

    yuv_chroma u_chroma
    (
        .clk         (clk),
        .blue_chroma (blue_chroma),
        .red_chroma  (red_chroma),
        .ofs         (ofs)
    );

    yuv_lane u_lane0
    (
        .clk   (clk),
        .luma  (luma0_reg),
        .ofs   (ofs),
        .pixel (first_pixel)
    );

    yuv_lane u_lane1
    (
        .clk   (clk),
        .luma  (luma1_reg),
        .ofs   (ofs),
        .pixel (second_pixel)
    );

    assign done          = valid_reg[1];
    assign last_pair_res = last_reg[1];

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[0]))
        else $error("result strobe without a transfer in flight");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted transfer produced no result");

    a_last_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !$isunknown(last_reg[0])) |=> (last_pair_res == $past(last_reg[0])))
        else $error("end-of-frame mark misaligned with result");
`endif

endmodule

@@ tb/sv/tb_yuv422_to_rgb565_converter.sv @@
module tb_yuv422_to_rgb565_converter;

    timeunit 1ns;
    timeprecision 1ps;

    import yuv_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        pixel_t first;
        pixel_t second;
        logic   last;
    } pixel_pair_t;

    class pixel_pair_scoreboard;
        pixel_pair_t expected_pairs[$];
        int          failures;

        function new();
            failures = 0;
        endfunction

        function automatic pixel_t predict_rgb565(int luma, int dr, int dg, int db);
            int r;
            int g;
            int b;
            pixel_t px;
            r = luma + dr;
            g = luma - dg;
            b = luma + db;
            r = (r < 0) ? 0 : ((r > 255) ? 255 : r);
            g = (g < 0) ? 0 : ((g > 255) ? 255 : g);
            b = (b < 0) ? 0 : ((b > 255) ? 255 : b);
            px[15:11] = r[7:3];
            px[10:5]  = g[7:2];
            px[4:0]   = b[7:3];
            return px;
        endfunction

        function automatic void note_macropixel(byte_t y0, byte_t u, byte_t y1, byte_t v,
                                                logic lp);
            int du;
            int dv;
            int dr;
            int dg;
            int db;
            pixel_pair_t pair;
            du = int'(u) - 128;
            dv = int'(v) - 128;
            // arithmetic shift of a signed int floors towards minus infinity
            dr = (dv * 359) >>> 8;
            dg = (du * 88 + dv * 183) >>> 8;
            db = (du * 454) >>> 8;
            pair.first  = predict_rgb565(int'(y0), dr, dg, db);
            pair.second = predict_rgb565(int'(y1), dr, dg, db);
            pair.last   = lp;
            expected_pairs.push_back(pair);
        endfunction

        function automatic void check_pixels(pixel_t p0, pixel_t p1, logic lp);
            pixel_pair_t want;
            if (expected_pairs.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: first %h second %h last %b", p0, p1, lp);
                return;
            end
            want = expected_pairs.pop_front();
            if (want.first !== p0 || want.second !== p1 || want.last !== lp) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected first %h second %h last %b, got %h %h %b",
                             want.first, want.second, want.last, p0, p1, lp);
            end
        endfunction

        function automatic int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    byte_t  first_luma;
    byte_t  blue_chroma;
    byte_t  second_luma;
    byte_t  red_chroma;
    logic   last_pair;
    logic   done;
    pixel_t first_pixel;
    pixel_t second_pixel;
    logic   last_pair_res;

    pixel_pair_scoreboard sb = new();

    yuv422_to_rgb565_converter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_luma    (first_luma),
        .blue_chroma   (blue_chroma),
        .second_luma   (second_luma),
        .red_chroma    (red_chroma),
        .last_pair     (last_pair),
        .done          (done),
        .first_pixel   (first_pixel),
        .second_pixel  (second_pixel),
        .last_pair_res (last_pair_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pre-edge values: the block's own updates land later in the step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_macropixel(first_luma, blue_chroma, second_luma, red_chroma,
                                   last_pair);
            if (done)
                sb.check_pixels(first_pixel, second_pixel, last_pair_res);
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic byte_t pick_byte();
        byte_t corners[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(6)];
        return byte_t'($urandom_range(255));
    endfunction

    task automatic send_macropixel(input byte_t y0, input byte_t u, input byte_t y1,
                                   input byte_t v, input logic lp, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start       <= 1'b0;
            first_luma  <= byte_t'($urandom_range(255));
            blue_chroma <= byte_t'($urandom_range(255));
            second_luma <= byte_t'($urandom_range(255));
            red_chroma  <= byte_t'($urandom_range(255));
            last_pair   <= 1'($urandom_range(1));
            @(posedge clk);
        end
        start       <= 1'b1;
        first_luma  <= y0;
        blue_chroma <= u;
        second_luma <= y1;
        red_chroma  <= v;
        last_pair   <= lp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
            send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                            ($urandom_range(15) == 0), idle_pct);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        first_luma  = '0;
        blue_chroma = '0;
        second_luma = '0;
        red_chroma  = '0;
        last_pair   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, neutral chroma, floor on negative products, clamping
        send_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 0);
        send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0);
        send_macropixel(8'd0,   8'd128, 8'd255, 8'd128, 1'b0, 0);
        send_macropixel(8'd128, 8'd128, 8'd127, 8'd127, 1'b0, 0);
        send_macropixel(8'd100, 8'd127, 8'd100, 8'd128, 1'b0, 0);
        send_macropixel(8'd100, 8'd129, 8'd100, 8'd127, 1'b1, 0);
        send_macropixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 0);
        send_macropixel(8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 0);
        send_macropixel(8'd0,   8'd255, 8'd16,  8'd0,   1'b0, 0);
        send_macropixel(8'd255, 8'd0,   8'd235, 8'd255, 1'b1, 0);
        send_macropixel(8'd7,   8'd1,   8'd248, 8'd254, 1'b0, 0);
        send_macropixel(8'd3,   8'd254, 8'd252, 8'd1,   1'b0, 0);
        send_macropixel(8'h55,  8'hAA,  8'hAA,  8'h55,  1'b1, 0);
        send_macropixel(8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0, 0);
        wait_for_results();

        run_random(280, 17);
        wait_for_results();
        run_random(280, 74);
        wait_for_results();
        run_random(290, 0);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/yuv_pkg.sv
rtl/yuv_chroma.sv
rtl/yuv_lane.sv
rtl/yuv422_to_rgb565_converter.sv
tb/sv/tb_yuv422_to_rgb565_converter.sv
